// ===== rtl/isol_pkg.sv =====
// shared constants, codes and control types for the interval overlap lookup
`default_nettype none

package isol_pkg;

   localparam int MAX_INTERVALS  = 1024;
   localparam int IDX_BITS       = $clog2(MAX_INTERVALS);
   localparam int CNT_BITS       = $clog2(MAX_INTERVALS + 1);
   localparam int MAX_REPORT     = 16;
   localparam int REP_BITS       = $clog2(MAX_REPORT + 1);
   localparam int POS_BITS       = 32;
   localparam int HIT_INDEX_BITS = 10;
   localparam int REQ_DATA_BITS  = 4 * POS_BITS;
   localparam int RSP_FIELD_BITS = HIT_INDEX_BITS + 2 * POS_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_NONE   = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      ST_ACK   = 3'd0,
      ST_HIT   = 3'd1,
      ST_NONE  = 3'd2,
      ST_FULL  = 3'd3,
      ST_ORDER = 3'd4
   } status_type;

   typedef struct packed {
      logic [POS_BITS-1:0] seg_end;
      logic [POS_BITS-1:0] seg_start;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic exec;
      logic srch_start;
      logic srch_read;
      logic srch_cmp;
      logic srch_next;
      logic hit_setup;
      logic hit_emit;
      logic single_emit;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      command_type cmd;
      logic        query_trivial;
      logic        srch_done;
      logic        srch_pass;
      logic        no_hits;
      logic        hit_last;
      logic        out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

// ===== rtl/isol_datapath.sv =====
// interval table memory, binary search registers and result register
`default_nettype none

module isol_datapath (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire  [1:0]                               req_tuser,
   input  wire  [isol_pkg::REQ_DATA_BITS-1:0]       req_tdata,
   input  wire  isol_pkg::dp_cmd_type               cmd,
   output isol_pkg::dp_stat_type                    stat,
   output logic                                     rsp_tvalid,
   input  wire                                      rsp_tready,
   output logic [isol_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   output logic [3:0]                               rsp_tuser,
   output logic                                     rsp_tlast
);

   localparam int PB = isol_pkg::POS_BITS;
   localparam int CB = isol_pkg::CNT_BITS;
   localparam int IB = isol_pkg::IDX_BITS;
   localparam int RB = isol_pkg::REP_BITS;

   // latched request
   isol_pkg::command_type req_cmd_ff;
   logic [PB-1:0]         ss_ff, se_ff, qs_ff, qe_ff;

   // table
   isol_pkg::entry_type   mem [isol_pkg::MAX_INTERVALS];
   isol_pkg::entry_type   rd_ff;
   logic                  rd_en;
   logic [IB-1:0]         rd_addr;
   logic                  wr_en;
   logic [CB-1:0]         count_ff;
   logic [PB-1:0]         last_end_ff;

   // search
   logic [CB-1:0]         lo_ff, hi_ff, a_ff;
   logic                  pass_ff;
   logic [CB:0]           mid_sum;
   logic [CB-1:0]         mid;
   logic                  go_left;

   // hit walk
   logic [IB-1:0]         idx_ff;
   logic [RB-1:0]         rem_ff;
   logic                  trunc_ff;
   logic [CB-1:0]         hits;
   logic                  hits_over;

   isol_pkg::status_type  single_st_ff;
   isol_pkg::status_type  exec_st;
   logic                  append_full, append_bad, query_trivial;

   // result register
   logic                  out_valid_ff;
   logic                  out_free, out_load;
   isol_pkg::status_type  out_st_ff;
   logic [isol_pkg::HIT_INDEX_BITS-1:0] out_idx_ff;
   logic [PB-1:0]         out_start_ff, out_end_ff;
   logic                  out_last_ff, out_trunc_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_cmd_ff <= isol_pkg::command_type'(req_tuser);
         ss_ff      <= req_tdata[PB-1:0];
         se_ff      <= req_tdata[2*PB-1:PB];
         qs_ff      <= req_tdata[3*PB-1:2*PB];
         qe_ff      <= req_tdata[4*PB-1:3*PB];
      end
   end

   assign append_full   = (count_ff == CB'(isol_pkg::MAX_INTERVALS));
   assign append_bad    = (se_ff < ss_ff) || ((count_ff != '0) && (ss_ff <= last_end_ff));
   assign query_trivial = (qe_ff < qs_ff) || (count_ff == '0);

   always_comb begin
      unique case (req_cmd_ff)
         isol_pkg::CMD_CLEAR:  exec_st = isol_pkg::ST_ACK;
         isol_pkg::CMD_APPEND: begin
            if (append_full) exec_st = isol_pkg::ST_FULL;
            else if (append_bad) exec_st = isol_pkg::ST_ORDER;
            else exec_st = isol_pkg::ST_ACK;
         end
         isol_pkg::CMD_QUERY:  exec_st = isol_pkg::ST_NONE;
         isol_pkg::CMD_NONE:   exec_st = isol_pkg::ST_NONE;
         default:              exec_st = isol_pkg::ST_NONE;
      endcase
   end

   assign wr_en = cmd.exec && (req_cmd_ff == isol_pkg::CMD_APPEND) && !append_full && !append_bad;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec && (req_cmd_ff == isol_pkg::CMD_CLEAR)) begin
         count_ff <= '0;
      end else if (wr_en) begin
         count_ff <= count_ff + CB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IB-1:0]] <= '{seg_end: se_ff, seg_start: ss_ff};
         last_end_ff           <= se_ff;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // binary search over [lo, hi)
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[CB:1];
   assign go_left = pass_ff ? !(rd_ff.seg_start <= qe_ff) : (rd_ff.seg_end >= qs_ff);

   assign hits      = lo_ff - a_ff;
   assign hits_over = hits > CB'(isol_pkg::MAX_REPORT);

   always_ff @(posedge clock) begin
      if (cmd.srch_start) begin
         lo_ff   <= '0;
         hi_ff   <= count_ff;
         pass_ff <= 1'b0;
      end else if (cmd.srch_next) begin
         a_ff    <= lo_ff;
         lo_ff   <= '0;
         hi_ff   <= count_ff;
         pass_ff <= 1'b1;
      end else if (cmd.srch_cmp) begin
         if (go_left) hi_ff <= mid;
         else lo_ff <= mid + CB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         single_st_ff <= exec_st;
      end else if (cmd.hit_setup) begin
         single_st_ff <= isol_pkg::ST_NONE;
      end
      if (cmd.hit_setup) begin
         idx_ff   <= a_ff[IB-1:0];
         trunc_ff <= hits_over;
         rem_ff   <= hits_over ? RB'(isol_pkg::MAX_REPORT) : RB'(hits);
      end else if (cmd.hit_emit && out_free) begin
         idx_ff <= idx_ff + IB'(1);
         rem_ff <= rem_ff - RB'(1);
      end
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = mid[IB-1:0];
      priority if (cmd.hit_setup) begin
         rd_en   = 1'b1;
         rd_addr = a_ff[IB-1:0];
      end else if (cmd.hit_emit) begin
         rd_en   = out_free && !stat.hit_last;
         rd_addr = idx_ff + IB'(1);
      end else if (cmd.srch_read) begin
         rd_en   = 1'b1;
      end else begin
         rd_en   = 1'b0;
      end
   end

   // result register
   assign out_free = !out_valid_ff || rsp_tready;
   assign out_load = (cmd.hit_emit || cmd.single_emit) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (cmd.hit_emit) begin
            out_st_ff    <= isol_pkg::ST_HIT;
            out_idx_ff   <= isol_pkg::HIT_INDEX_BITS'(idx_ff);
            out_start_ff <= rd_ff.seg_start;
            out_end_ff   <= rd_ff.seg_end;
            out_last_ff  <= stat.hit_last;
            out_trunc_ff <= trunc_ff;
         end else begin
            out_st_ff    <= single_st_ff;
            out_idx_ff   <= '0;
            out_start_ff <= '0;
            out_end_ff   <= '0;
            out_last_ff  <= 1'b1;
            out_trunc_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(isol_pkg::RSP_DATA_BITS - isol_pkg::RSP_FIELD_BITS){1'b0}},
                        out_end_ff, out_start_ff, out_idx_ff};
   assign rsp_tuser  = {out_trunc_ff, out_st_ff};
   assign rsp_tlast  = out_last_ff;

   assign stat.cmd           = req_cmd_ff;
   assign stat.query_trivial = query_trivial;
   assign stat.srch_done     = (lo_ff >= hi_ff);
   assign stat.srch_pass     = pass_ff;
   assign stat.no_hits       = (a_ff >= lo_ff);
   assign stat.hit_last      = (rem_ff == RB'(1));
   assign stat.out_free      = out_free;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(isol_pkg::MAX_INTERVALS))
      else $error("interval count above table size");

   a_probe_range: assert property (@(posedge clock) disable iff (reset)
      cmd.srch_read |-> (lo_ff < hi_ff) && (hi_ff <= count_ff))
      else $error("probe outside search window");

   a_hit_budget: assert property (@(posedge clock) disable iff (reset)
      cmd.hit_emit |-> (rem_ff != '0) && (rem_ff <= RB'(isol_pkg::MAX_REPORT)))
      else $error("hit walk with no reports left");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_tvalid)
      else $error("loaded result not presented");

endmodule

`default_nettype wire

// ===== rtl/isol_ctrl.sv =====
// controller state machine sequencing decode, searches and result emission
`default_nettype none

module isol_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   input  wire  isol_pkg::dp_stat_type stat,
   output isol_pkg::dp_cmd_type       cmd
);

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_EXEC      = 7'b0000010,
      S_SRCH_RD   = 7'b0000100,
      S_SRCH_CMP  = 7'b0001000,
      S_HIT_SETUP = 7'b0010000,
      S_HIT_OUT   = 7'b0100000,
      S_EMIT1     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            unique case (stat.cmd)
               isol_pkg::CMD_CLEAR:  state_in = S_EMIT1;
               isol_pkg::CMD_APPEND: state_in = S_EMIT1;
               isol_pkg::CMD_QUERY: begin
                  if (stat.query_trivial) begin
                     state_in = S_EMIT1;
                  end else begin
                     cmd.srch_start = 1'b1;
                     state_in       = S_SRCH_RD;
                  end
               end
               isol_pkg::CMD_NONE:   state_in = S_IDLE;
               default:              state_in = S_IDLE;
            endcase
         end
         S_SRCH_RD: begin
            if (stat.srch_done) begin
               if (!stat.srch_pass) begin
                  cmd.srch_next = 1'b1;
               end else begin
                  state_in = S_HIT_SETUP;
               end
            end else begin
               cmd.srch_read = 1'b1;
               state_in      = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            cmd.srch_cmp = 1'b1;
            state_in     = S_SRCH_RD;
         end
         S_HIT_SETUP: begin
            cmd.hit_setup = 1'b1;
            state_in      = stat.no_hits ? S_EMIT1 : S_HIT_OUT;
         end
         S_HIT_OUT: begin
            cmd.hit_emit = 1'b1;
            if (stat.out_free && stat.hit_last) begin
               state_in = S_IDLE;
            end
         end
         S_EMIT1: begin
            cmd.single_emit = 1'b1;
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_search_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH_CMP) |=> (state_ff == S_SRCH_RD))
      else $error("compare step not followed by next probe");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second transaction taken before decode");

   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_EMIT1) && stat.out_free) |=> (state_ff == S_IDLE))
      else $error("single result left controller busy");

endmodule

`default_nettype wire

// ===== rtl/interval_segment_overlap_lookup.sv =====
// top level of the sorted interval table with binary-search overlap queries
// clear and append: latch, decode and execute, then one result through the output register
// query: decode, then two binary searches of up to clog2(count+1) probes (S_SRCH_RD read then
//   S_SRCH_CMP compare), hit setup, one hit per cycle unless output stalls (at most 16)
// one transaction in work at a time; the next is taken as soon as the controller is idle,
//   while the last result may still wait in the output register
// reset clears the interval count, controller state and result valid; table contents stay
`default_nettype none

module interval_segment_overlap_lookup (
   input  wire                                  clock,
   input  wire                                  reset,
   // request channel
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // seg_start, seg_end, query_start, query_end (32 bits each, lowest first)
   input  wire  [isol_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // command
   input  wire  [1:0]                           req_tuser,
   // response channel
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // hit_index (10), hit_start (32), hit_end (32), zero fill to 80
   output logic [isol_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // status (3), truncated (1)
   output logic [3:0]                           rsp_tuser,
   // last result of the transaction
   output logic                                 rsp_tlast
);

   // command and status between controller and datapath
   isol_pkg::dp_cmd_type  cmd;
   isol_pkg::dp_stat_type stat;

   // sequencing: decode, two searches, hit walk
   isol_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // table memory, search window and output register
   isol_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
